@@ design/led_pixel_symbol_encoder_top_defines.svh @@
// Assertion macros for the LED pixel symbol encoder.
// The assertions sample on clk and are held off while rst_n is low.
`ifndef LED_PIXEL_SYMBOL_ENCODER_TOP_DEFINES_SVH
`define LED_PIXEL_SYMBOL_ENCODER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LPSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpse assertion failed");
`define LPSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpse assertion failed");
`else
`define LPSE_ASSERT_NOW(label, ante, cons)
`define LPSE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/lpse_pkg.sv @@
`timescale 1ns / 1ps

package lpse_pkg;

    localparam int unsigned BITS_PER_PIXEL = 24;
    localparam int unsigned COUNT_W        = 5;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [15:0] SYM_ZERO_BIT = 16'h02AA;
    localparam logic [15:0] SYM_ONE_BIT  = 16'hAAAA;
    localparam logic [6:0]  PCT_FULL     = 7'd100;

    // floor(p / 100) equals (p * 5243) >> 19 for every p below 43690.
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;

    typedef struct packed {
        logic        valid;
        logic [23:0] grb;
    } grb_word_t;

    function automatic logic [7:0] div_by_100(input logic [14:0] p);
        logic [27:0] m;
        m = 28'(p) * 28'(RECIP_100);
        return m[RECIP_SHIFT +: 8];
    endfunction

endpackage

@@ design/lpse_front.sv @@
`timescale 1ns / 1ps

module lpse_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    input  logic [6:0]          brightness,
    input  logic                queue_full,
    output lpse_pkg::grb_word_t push_word
);
    import lpse_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [14:0] prod_r_reg;
    logic [14:0] prod_g_reg;
    logic [14:0] prod_b_reg;
    logic        load;

    // The product stage holds its word until the queue has room for it.
    assign in_stall = s1_valid_reg && queue_full;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (!in_stall)
        begin
            s1_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_r_reg <= 15'(red)   * 15'(brightness);
            prod_g_reg <= 15'(green) * 15'(brightness);
            prod_b_reg <= 15'(blue)  * 15'(brightness);
        end
    end

    assign push_word.valid = s1_valid_reg && !queue_full;
    assign push_word.grb   = {div_by_100(prod_g_reg), div_by_100(prod_r_reg),
                              div_by_100(prod_b_reg)};

endmodule

@@ design/lpse_queue.sv @@
`timescale 1ns / 1ps

module lpse_queue #(
    parameter int unsigned DEPTH = lpse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lpse_pkg::grb_word_t push_word,
    output logic                full,
    input  logic                pop,
    output lpse_pkg::grb_word_t head
);
    import lpse_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [23:0]      entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.grb   = entry_reg[rd_ptr_reg];

    assign do_push = push_word.valid && !full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_word.grb;
        end
    end

endmodule

@@ design/lpse_back.sv @@
`timescale 1ns / 1ps

module lpse_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lpse_pkg::grb_word_t head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [15:0]         symbol_word,
    output logic                last_symbol
);
    import lpse_pkg::*;

    logic               busy_reg;
    logic               busy_next;
    logic [23:0]        shift_reg;
    logic [23:0]        shift_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               accept;
    logic               done;

    assign out_valid   = busy_reg;
    assign last_symbol = (count_reg == COUNT_W'(1));
    assign symbol_word = shift_reg[23] ? SYM_ONE_BIT : SYM_ZERO_BIT;

    // A new pixel loads in the cycle its last word is taken, so queued pixels run gap-free.
    assign accept = busy_reg && !out_stall;
    assign done   = !busy_reg || (accept && last_symbol);
    assign pop    = done && head.valid;

    always_comb
    begin
        busy_next  = busy_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        priority if (pop)
        begin
            busy_next  = 1'b1;
            shift_next = head.grb;
            count_next = COUNT_W'(BITS_PER_PIXEL);
        end
        else if (done)
        begin
            busy_next  = 1'b0;
            count_next = '0;
        end
        else if (accept)
        begin
            shift_next = {shift_reg[22:0], 1'b0};
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

endmodule

@@ design/led_pixel_symbol_encoder_top.sv @@
// Channel   Handshake            Word
// input     in_valid / in_stall  red, green, blue (8 bits each)
// output    out_valid/ out_stall symbol_word (16 bits), last_symbol
// config    brightness_percent_we brightness_percent (7 bits, clamped to 100)
//
// Each pixel produces 24 output words, one per cycle while not stalled, set
// by the serializer that shifts out one bit per cycle; queued pixels follow
// each other with no gap. An accepted pixel passes the product stage and the
// queue into the serializer. Reset empties the pipe and sets brightness to
// 100. A stalled output holds its word; the front keeps accepting until the
// queue and the product stage are full.
`timescale 1ns / 1ps

module led_pixel_symbol_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = lpse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] symbol_word,
    output logic        last_symbol,
    input  logic        brightness_percent_we,
    input  logic [6:0]  brightness_percent
);
    import lpse_pkg::*;

    `include "led_pixel_symbol_encoder_top_defines.svh"

    logic [6:0] brightness_reg;
    logic [6:0] brightness_next;
    grb_word_t  push_word;
    grb_word_t  head;
    logic       queue_full;
    logic       pop;

    always_comb
    begin
        brightness_next = brightness_reg;
        if (brightness_percent_we)
        begin
            brightness_next = (brightness_percent > PCT_FULL) ? PCT_FULL
                                                              : brightness_percent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= PCT_FULL;
        end
        else
        begin
            brightness_reg <= brightness_next;
        end
    end

    lpse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .brightness (brightness_reg),
        .queue_full (queue_full),
        .push_word  (push_word)
    );

    lpse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_word (push_word),
        .full      (queue_full),
        .pop       (pop),
        .head      (head)
    );

    lpse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .symbol_word (symbol_word),
        .last_symbol (last_symbol)
    );

    `LPSE_ASSERT_NOW(a_brightness_range, 1'b1, brightness_reg <= PCT_FULL)
    `LPSE_ASSERT_NOW(a_pop_has_word, pop, head.valid)
    `LPSE_ASSERT_NEXT(a_pixel_continues, out_valid && !out_stall && !last_symbol, out_valid)

endmodule

@@ test/lpse_symbol_checker.sv @@
`timescale 1ns / 1ps

module lpse_symbol_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] symbol_word,
    input  logic        last_symbol,
    input  logic        brightness_percent_we,
    input  logic [6:0]  brightness_percent,
    output int          fail_count,
    output int          symbols_pending
);
    import lpse_pkg::*;

    typedef struct packed {
        logic [15:0] word;
        logic        last;
    } line_symbol_t;

    line_symbol_t expected_symbols[$];
    logic [6:0]   brightness_now;

    function automatic logic [7:0] dim_channel(input logic [7:0] level, input logic [6:0] pct);
        int unsigned product;
        product = 32'(level) * 32'(pct);
        return 8'(product / 32'(PCT_FULL));
    endfunction

    // One pixel turns into 24 symbols: green, red, blue, each MSB first.
    task automatic queue_pixel_symbols(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
        logic [23:0]  grb;
        line_symbol_t sym;
        grb = {dim_channel(g, brightness_now), dim_channel(r, brightness_now),
               dim_channel(b, brightness_now)};
        for (int k = 23; k >= 0; k--)
        begin
            sym.word = grb[k] ? SYM_ONE_BIT : SYM_ZERO_BIT;
            sym.last = (k == 0);
            expected_symbols.push_back(sym);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_symbol_t want;
        if (!rst_n)
        begin
            expected_symbols.delete();
            brightness_now  <= PCT_FULL;
            fail_count      = 0;
            symbols_pending <= 0;
        end
        else
        begin
            if (brightness_percent_we)
                brightness_now <= (brightness_percent > PCT_FULL) ? PCT_FULL : brightness_percent;
            // Compare before queueing, so a word can never match a pixel taken this edge.
            if (out_valid && !out_stall)
            begin
                if (expected_symbols.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got word %h last %b",
                             $time, symbol_word, last_symbol);
                    fail_count++;
                end
                else
                begin
                    want = expected_symbols.pop_front();
                    if (symbol_word !== want.word)
                    begin
                        $display("%0t: symbol_word mismatch, expected %h, got %h",
                                 $time, want.word, symbol_word);
                        fail_count++;
                    end
                    if (last_symbol !== want.last)
                    begin
                        $display("%0t: last_symbol mismatch, expected %b, got %b",
                                 $time, want.last, last_symbol);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                queue_pixel_symbols(red, green, blue);
            symbols_pending <= expected_symbols.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  red = 8'd0;
    logic [7:0]  green = 8'd0;
    logic [7:0]  blue = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] symbol_word;
    logic        last_symbol;
    logic        brightness_percent_we = 1'b0;
    logic [6:0]  brightness_percent = 7'd0;

    int fail_count;
    int symbols_pending;
    int sender_idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    always #2 clk = ~clk;

    led_pixel_symbol_encoder_top DUT (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .red                   (red),
        .green                 (green),
        .blue                  (blue),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .symbol_word           (symbol_word),
        .last_symbol           (last_symbol),
        .brightness_percent_we (brightness_percent_we),
        .brightness_percent    (brightness_percent)
    );

    lpse_symbol_checker u_checker (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .red                   (red),
        .green                 (green),
        .blue                  (blue),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .symbol_word           (symbol_word),
        .last_symbol           (last_symbol),
        .brightness_percent_we (brightness_percent_we),
        .brightness_percent    (brightness_percent),
        .fail_count            (fail_count),
        .symbols_pending       (symbols_pending)
    );

    // Receiver side. A long hold-off request overrides the random stalls.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (symbols_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_brightness(input logic [6:0] pct);
        wait_drained();
        brightness_percent_we <= 1'b1;
        brightness_percent    <= pct;
        @(posedge clk);
        brightness_percent_we <= 1'b0;
    endtask

    task automatic send_random_pixels(input int count);
        for (int n = 0; n < count; n++)
            send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset brightness is full scale.
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'h80, 8'h01, 8'hAA);
        send_pixel(8'h55, 8'h7F, 8'hFE);
        // Writes above 100 are clamped to full scale.
        write_brightness(7'd127);
        send_pixel(8'hFF, 8'h80, 8'h01);
        send_pixel(8'hC8, 8'h63, 8'h32);
        write_brightness(7'd101);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        // Zero brightness gives only zero-bit patterns.
        write_brightness(7'd0);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hAA, 8'h55, 8'hC3);
        write_brightness(7'd1);
        send_pixel(8'hFF, 8'h64, 8'h63);
        write_brightness(7'd99);
        send_pixel(8'hFF, 8'h65, 8'h01);
        write_brightness(7'd50);
        send_pixel(8'h03, 8'h02, 8'h01);

        // No idling; the long hold-off backs the block up into its input.
        write_brightness(7'd100);
        send_random_pixels(10);
        hold_request = 400;
        send_random_pixels(45);

        write_brightness(7'($urandom_range(0, 127)));
        sender_idle_pct = 73;
        stall_pct       = 0;
        send_random_pixels(55);

        write_brightness(7'($urandom_range(0, 127)));
        sender_idle_pct = 0;
        stall_pct       = 73;
        send_random_pixels(55);

        write_brightness(7'($urandom_range(1, 99)));
        sender_idle_pct = 17;
        stall_pct       = 17;
        send_random_pixels(55);

        wait_drained();
        repeat (30) @(posedge clk);
        if (fail_count == 0 && symbols_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/lpse_pkg.sv
design/lpse_front.sv
design/lpse_queue.sv
design/lpse_back.sv
design/led_pixel_symbol_encoder_top.sv
test/lpse_symbol_checker.sv
test/tb_top.sv
